[hw/rtl/dwvp_pkg.sv]
// ----------------------------------------------------------------------------
// Dual wheel velocity PID package
// Shared constants, sequencer operations, micro-program and handshake structs.
// ----------------------------------------------------------------------------
package dwvp_pkg;

   localparam int NUM_W    = 60;
   localparam int DEN_W    = 24;
   localparam int DIV_STEP = 4;

   localparam logic [18:0] TWO_PI_Q16   = 19'd411775;
   localparam logic [23:0] MIN_ELAPSED  = 24'd50000;
   localparam logic [23:0] US_PER_S     = 24'd1000000;
   localparam logic [23:0] FILTER_DIV   = 24'd25;
   localparam logic [60:0] PROD_LIMIT   = 61'h1000_0000_0000_0000;

   localparam logic [2:0] REG_KP    = 3'd0;
   localparam logic [2:0] REG_KI    = 3'd1;
   localparam logic [2:0] REG_KD    = 3'd2;
   localparam logic [2:0] REG_UPPER = 3'd3;
   localparam logic [2:0] REG_LOWER = 3'd4;
   localparam logic [2:0] REG_RPT   = 3'd5;

   localparam logic signed [31:0] KP_RESET    = 32'sd65536;
   localparam logic [7:0]         UPPER_RESET = 8'd255;
   localparam logic signed [8:0]  LOWER_RESET = -9'sd255;
   localparam logic [31:0]        RPT_RESET   = 32'd26353589;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_TICK, OP_STEP, OP_ASUM, OP_DIV, OP_AWRAP, OP_RMUL,
      OP_RAW, OP_FSUM, OP_FILT, OP_ERR, OP_EMUL, OP_DER, OP_INT, OP_MULP,
      OP_MULD, OP_MULIL, OP_MULIH, OP_ACC, OP_DRIVE, OP_PUBLISH
   } op_type;

   localparam logic [4:0] PROG_LAST = 5'd24;

   typedef struct packed {
      op_type op;
      logic   wheel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic short_tick;
   } status_type;

   function automatic op_type prog_op(input logic [4:0] pc);
      op_type op;
      case (pc)
         5'd0:    op = OP_TICK;
         5'd1:    op = OP_STEP;
         5'd2:    op = OP_ASUM;
         5'd3:    op = OP_DIV;
         5'd4:    op = OP_AWRAP;
         5'd5:    op = OP_RMUL;
         5'd6:    op = OP_DIV;
         5'd7:    op = OP_RAW;
         5'd8:    op = OP_FSUM;
         5'd9:    op = OP_DIV;
         5'd10:   op = OP_FILT;
         5'd11:   op = OP_ERR;
         5'd12:   op = OP_EMUL;
         5'd13:   op = OP_DIV;
         5'd14:   op = OP_DER;
         5'd15:   op = OP_DIV;
         5'd16:   op = OP_INT;
         5'd17:   op = OP_MULP;
         5'd18:   op = OP_ACC;
         5'd19:   op = OP_MULD;
         5'd20:   op = OP_ACC;
         5'd21:   op = OP_MULIL;
         5'd22:   op = OP_MULIH;
         5'd23:   op = OP_ACC;
         5'd24:   op = OP_DRIVE;
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

[hw/rtl/dual_wheel_velocity_pid.sv]
// ----------------------------------------------------------------------------
// Dual wheel velocity PID
// Each control tick runs two wheels of 25 sequencer steps each, five of
// them divisions in the shared 4-bit-per-cycle divider.
// A short tick is dropped in the check state after it is accepted. One tick in flight.
// Synchronous reset restores the register defaults and clears the per-wheel history.
// ----------------------------------------------------------------------------
module dual_wheel_velocity_pid (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_left_count,
   input  logic signed [31:0] req_right_count,
   input  logic signed [31:0] req_left_target,
   input  logic signed [31:0] req_right_target,
   input  logic [23:0]        req_elapsed_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_left_duty,
   output logic [1:0]         rsp_left_direction,
   output logic [7:0]         rsp_right_duty,
   output logic [1:0]         rsp_right_direction,
   output logic signed [31:0] rsp_left_velocity,
   output logic signed [31:0] rsp_right_velocity,
   output logic [18:0]        rsp_left_angle,
   output logic [18:0]        rsp_right_angle
);
   import dwvp_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   dwvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dwvp_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_left_count      (req_left_count),
      .req_right_count     (req_right_count),
      .req_left_target     (req_left_target),
      .req_right_target    (req_right_target),
      .req_elapsed_us      (req_elapsed_us),
      .rsp_left_duty       (rsp_left_duty),
      .rsp_left_direction  (rsp_left_direction),
      .rsp_right_duty      (rsp_right_duty),
      .rsp_right_direction (rsp_right_direction),
      .rsp_left_velocity   (rsp_left_velocity),
      .rsp_right_velocity  (rsp_right_velocity),
      .rsp_left_angle      (rsp_left_angle),
      .rsp_right_angle     (rsp_right_angle)
   );

   a_publish_when_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("Result raised while the block was idle.");

   a_left_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_left_duty == 8'd0) == (rsp_left_direction == DIR_STOP)))
      else $error("Left duty and direction disagree.");

   a_right_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_right_duty == 8'd0) == (rsp_right_direction == DIR_STOP)))
      else $error("Right duty and direction disagree.");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_angle <= TWO_PI_Q16 && rsp_right_angle <= TWO_PI_Q16))
      else $error("Wheel angle beyond one turn.");

endmodule

[hw/rtl/dwvp_div.sv]
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, several quotient bits per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module dwvp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dwvp_pkg::NUM_W-1:0]  num,
   input  logic [dwvp_pkg::DEN_W-1:0]  den,
   output logic [dwvp_pkg::NUM_W-1:0]  quo,
   output logic [dwvp_pkg::DEN_W-1:0]  rem,
   output logic                        done
);
   import dwvp_pkg::*;

   localparam int ITERS = NUM_W / DIV_STEP;
   localparam int CNT_W = $clog2(ITERS + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [NUM_W-1:0] quo_in;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial  = {rem_in, quo_in[NUM_W-1]};
         quo_in = {quo_in[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            trial     = trial - {1'b0, den};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ITERS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

[hw/rtl/dwvp_datapath.sv]
// ----------------------------------------------------------------------------
// Dual wheel velocity PID datapath
// Configuration and wheel state, one operation per command, shared divider.
// ----------------------------------------------------------------------------
module dwvp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dwvp_pkg::cmd_type    cmd,
   output dwvp_pkg::status_type status,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic signed [31:0]   req_left_count,
   input  logic signed [31:0]   req_right_count,
   input  logic signed [31:0]   req_left_target,
   input  logic signed [31:0]   req_right_target,
   input  logic [23:0]          req_elapsed_us,
   output logic [7:0]           rsp_left_duty,
   output logic [1:0]           rsp_left_direction,
   output logic [7:0]           rsp_right_duty,
   output logic [1:0]           rsp_right_direction,
   output logic signed [31:0]   rsp_left_velocity,
   output logic signed [31:0]   rsp_right_velocity,
   output logic [18:0]          rsp_left_angle,
   output logic [18:0]          rsp_right_angle
);
   import dwvp_pkg::*;

   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic [7:0]         upper_ff;
   logic signed [8:0]  lower_ff;
   logic [31:0]        rpt_ff;

   logic [31:0]        cnt_ff   [2];
   logic signed [31:0] tgt_ff   [2];
   logic [23:0]        dt_ff;
   logic [31:0]        last_ff  [2];
   logic signed [31:0] filt_ff  [2];
   logic signed [31:0] praw_ff  [2];
   logic signed [31:0] perr_ff  [2];
   logic signed [47:0] integ_ff [2];
   logic [18:0]        angle_ff [2];
   logic [7:0]         duty_ff  [2];
   logic [1:0]         dir_ff   [2];

   logic               neg_ff, ineg_ff, big_ff, pneg_ff;
   logic [31:0]        mag_ff;
   logic [47:0]        m_ff;
   logic signed [49:0] asum_ff;
   logic [NUM_W-1:0]   num_ff, ipend_ff;
   logic [DEN_W-1:0]   den_ff;
   logic signed [31:0] raw_ff, err_ff, der_ff;
   logic [79:0]        prod_ff;
   logic signed [63:0] acc_ff;

   logic               w;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   quo;
   logic [DEN_W-1:0]   rem;

   logic [31:0]        ticks;
   logic signed [49:0] step_s, asum_c;
   logic [49:0]        asum_mag;
   logic [18:0]        angle_c;
   logic signed [31:0] sat_q;
   logic signed [37:0] fsum_c;
   logic signed [32:0] ediff, ddiff;
   logic signed [31:0] err_c;
   logic [32:0]        dmag;
   logic [31:0]        emag, dermag, kpmag, kimag, kdmag;
   logic [47:0]        imag;
   logic signed [49:0] isum;
   logic signed [47:0] integ_c;
   logic [60:0]        psat;
   logic signed [63:0] adj;
   logic signed [31:0] drv, drv_c, drv_mag;
   logic [7:0]         duty_c;
   logic [1:0]         dir_c;

   assign w         = cmd.wheel;
   assign div_start = (cmd.op == OP_DIV);

   dwvp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo),
      .rem   (rem),
      .done  (div_done)
   );

   assign status.div_done   = div_done;
   assign status.short_tick = (dt_ff < MIN_ELAPSED);

   always_comb begin
      ticks    = cnt_ff[w] - last_ff[w];
      step_s   = neg_ff ? -$signed({2'b00, m_ff}) : $signed({2'b00, m_ff});
      asum_c   = $signed({31'b0, angle_ff[w]}) + step_s;
      asum_mag = asum_c[49] ? 50'(-asum_c) : 50'(asum_c);

      if (asum_ff > $signed({31'b0, TWO_PI_Q16})) begin
         angle_c = (rem[18:0] == '0) ? TWO_PI_Q16 : rem[18:0];
      end else if (asum_ff < 0) begin
         angle_c = (rem[18:0] == '0) ? '0 : TWO_PI_Q16 - rem[18:0];
      end else begin
         angle_c = asum_ff[18:0];
      end

      if (neg_ff) begin
         if ((|quo[NUM_W-1:32]) || (quo[31] && (|quo[30:0]))) begin
            sat_q = 32'sh8000_0000;
         end else begin
            sat_q = -$signed(quo[31:0]);
         end
      end else begin
         if (|quo[NUM_W-1:31]) begin
            sat_q = 32'sh7FFF_FFFF;
         end else begin
            sat_q = $signed(quo[31:0]);
         end
      end

      fsum_c = 38'(filt_ff[w]) * 38'sd23 + 38'(raw_ff) + 38'(praw_ff[w]);

      ediff = 33'(tgt_ff[w]) - 33'(filt_ff[w]);
      if (ediff > 33'sh0_7FFF_FFFF) begin
         err_c = 32'sh7FFF_FFFF;
      end else if (ediff < -33'sh0_8000_0000) begin
         err_c = 32'sh8000_0000;
      end else begin
         err_c = ediff[31:0];
      end

      ddiff  = 33'(err_ff) - 33'(perr_ff[w]);
      dmag   = ddiff[32] ? 33'(-ddiff) : 33'(ddiff);
      emag   = err_ff[31] ? 32'(-err_ff) : 32'(err_ff);
      dermag = der_ff[31] ? 32'(-der_ff) : 32'(der_ff);
      kpmag  = kp_ff[31] ? 32'(-kp_ff) : 32'(kp_ff);
      kimag  = ki_ff[31] ? 32'(-ki_ff) : 32'(ki_ff);
      kdmag  = kd_ff[31] ? 32'(-kd_ff) : 32'(kd_ff);
      imag   = integ_ff[w][47] ? 48'(-integ_ff[w]) : 48'(integ_ff[w]);

      isum = 50'(integ_ff[w]) + (neg_ff ? -$signed({1'b0, quo[48:0]})
                                        : $signed({1'b0, quo[48:0]}));
      if (isum > 50'sh0_7FFF_FFFF_FFFF) begin
         integ_c = 48'sh7FFF_FFFF_FFFF;
      end else if (isum < -50'sh0_8000_0000_0000) begin
         integ_c = 48'sh8000_0000_0000;
      end else begin
         integ_c = isum[47:0];
      end

      psat = (prod_ff > 80'(PROD_LIMIT)) ? PROD_LIMIT : prod_ff[60:0];

      adj = acc_ff + (acc_ff[63] ? 64'sh0000_0000_FFFF_FFFF : 64'sh0);
      drv = adj[63:32];
      if (drv > $signed({24'b0, upper_ff})) begin
         drv_c = $signed({24'b0, upper_ff});
      end else if (drv < 32'(lower_ff)) begin
         drv_c = 32'(lower_ff);
      end else begin
         drv_c = drv;
      end
      drv_mag = drv_c[31] ? -drv_c : drv_c;
      if ((tgt_ff[w] == '0) || (drv_c == '0)) begin
         duty_c = '0;
         dir_c  = DIR_STOP;
      end else begin
         duty_c = (drv_mag > 32'sd255) ? 8'd255 : drv_mag[7:0];
         dir_c  = drv_c[31] ? DIR_REV : DIR_FWD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= KP_RESET;
         ki_ff    <= '0;
         kd_ff    <= '0;
         upper_ff <= UPPER_RESET;
         lower_ff <= LOWER_RESET;
         rpt_ff   <= RPT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_KP:    kp_ff    <= csr_data;
            REG_KI:    ki_ff    <= csr_data;
            REG_KD:    kd_ff    <= csr_data;
            REG_UPPER: upper_ff <= csr_data[7:0];
            REG_LOWER: lower_ff <= csr_data[8:0];
            REG_RPT:   rpt_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            last_ff[i]  <= '0;
            filt_ff[i]  <= '0;
            praw_ff[i]  <= '0;
            perr_ff[i]  <= '0;
            integ_ff[i] <= '0;
            angle_ff[i] <= '0;
         end
      end else begin
         case (cmd.op)
            OP_TICK:  last_ff[w]  <= cnt_ff[w];
            OP_AWRAP: angle_ff[w] <= angle_c;
            OP_FSUM:  praw_ff[w]  <= raw_ff;
            OP_FILT:  filt_ff[w]  <= neg_ff ? -$signed(quo[31:0]) : $signed(quo[31:0]);
            OP_EMUL:  perr_ff[w]  <= err_ff;
            OP_INT:   integ_ff[w] <= integ_c;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cnt_ff[0] <= req_left_count;
            cnt_ff[1] <= req_right_count;
            tgt_ff[0] <= req_left_target;
            tgt_ff[1] <= req_right_target;
            dt_ff     <= req_elapsed_us;
         end
         OP_TICK: begin
            neg_ff <= ticks[31];
            mag_ff <= ticks[31] ? -ticks : ticks;
            acc_ff <= '0;
         end
         OP_STEP: m_ff <= 48'((64'(mag_ff) * 64'(rpt_ff)) >> 16);
         OP_ASUM: begin
            asum_ff <= asum_c;
            num_ff  <= NUM_W'(asum_mag);
            den_ff  <= DEN_W'(TWO_PI_Q16);
         end
         OP_RMUL: begin
            num_ff <= NUM_W'(57'(m_ff[36:0]) * 57'(US_PER_S));
            den_ff <= dt_ff;
            big_ff <= |m_ff[47:37];
         end
         OP_RAW: begin
            if (big_ff) begin
               raw_ff <= neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               raw_ff <= sat_q;
            end
         end
         OP_FSUM: begin
            neg_ff <= fsum_c[37];
            num_ff <= NUM_W'(fsum_c[37] ? 38'(-fsum_c) : 38'(fsum_c));
            den_ff <= FILTER_DIV;
         end
         OP_ERR: err_ff <= err_c;
         OP_EMUL: begin
            neg_ff   <= ddiff[32];
            num_ff   <= NUM_W'(53'(dmag) * 53'(US_PER_S));
            den_ff   <= dt_ff;
            ineg_ff  <= err_ff[31];
            ipend_ff <= NUM_W'(56'(emag) * 56'(dt_ff));
         end
         OP_DER: begin
            der_ff <= sat_q;
            neg_ff <= ineg_ff;
            num_ff <= ipend_ff;
            den_ff <= US_PER_S;
         end
         OP_MULP: begin
            prod_ff <= 80'(64'(kpmag) * 64'(emag));
            pneg_ff <= kp_ff[31] ^ err_ff[31];
         end
         OP_MULD: begin
            prod_ff <= 80'(64'(kdmag) * 64'(dermag));
            pneg_ff <= kd_ff[31] ^ der_ff[31];
         end
         OP_MULIL: begin
            prod_ff <= 80'(64'(kimag) * 64'(imag[31:0]));
            pneg_ff <= ki_ff[31] ^ integ_ff[w][47];
         end
         OP_MULIH: prod_ff <= prod_ff + {48'(kimag) * 48'(imag[47:32]), 32'b0};
         OP_ACC:   acc_ff  <= acc_ff + (pneg_ff ? -$signed({3'b0, psat})
                                                : $signed({3'b0, psat}));
         OP_DRIVE: begin
            duty_ff[w] <= duty_c;
            dir_ff[w]  <= dir_c;
         end
         OP_PUBLISH: begin
            rsp_left_duty       <= duty_ff[0];
            rsp_left_direction  <= dir_ff[0];
            rsp_right_duty      <= duty_ff[1];
            rsp_right_direction <= dir_ff[1];
            rsp_left_velocity   <= filt_ff[0];
            rsp_right_velocity  <= filt_ff[1];
            rsp_left_angle      <= angle_ff[0];
            rsp_right_angle     <= angle_ff[1];
         end
         default: ;
      endcase
   end

endmodule

[hw/rtl/dwvp_ctrl.sv]
// ----------------------------------------------------------------------------
// Dual wheel velocity PID controller
// Handshakes and micro-program sequencer driving the datapath, wheel by wheel.
// ----------------------------------------------------------------------------
module dwvp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dwvp_pkg::cmd_type    cmd,
   input  dwvp_pkg::status_type status
);
   import dwvp_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_RUN, ST_PUBLISH} state_type;

   state_type  state_ff;
   logic [4:0] pc_ff;
   logic       wheel_ff;
   logic       wait_ff;
   logic       rsp_valid_ff;
   op_type     prog;

   assign prog      = prog_op(pc_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.wheel = wheel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_RUN: begin
            if (!(prog == OP_DIV && wait_ff)) begin
               cmd.op = prog;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = OP_PUBLISH;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         wheel_ff     <= 1'b0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_PUBLISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               pc_ff    <= '0;
               wheel_ff <= 1'b0;
               state_ff <= status.short_tick ? ST_IDLE : ST_RUN;
            end
            ST_RUN: begin
               if (prog == OP_DIV && !wait_ff) begin
                  wait_ff <= 1'b1;
               end else if (prog != OP_DIV || status.div_done) begin
                  wait_ff <= 1'b0;
                  if (pc_ff == PROG_LAST) begin
                     pc_ff    <= '0;
                     wheel_ff <= ~wheel_ff;
                     if (wheel_ff) begin
                        state_ff <= ST_PUBLISH;
                     end
                  end else begin
                     pc_ff <= pc_ff + 1'b1;
                  end
               end
            end
            ST_PUBLISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[sim/pid_tick_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Control tick checker for the dual wheel velocity PID
// Watches the register, tick and drive channels, predicts each drive result
// from its own copy of the wheel state and compares it field by field.
// ----------------------------------------------------------------------------
module pid_tick_checker
   import dwvp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_left_count,
   input  logic signed [31:0] req_right_count,
   input  logic signed [31:0] req_left_target,
   input  logic signed [31:0] req_right_target,
   input  logic [23:0]        req_elapsed_us,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_left_duty,
   input  logic [1:0]         rsp_left_direction,
   input  logic [7:0]         rsp_right_duty,
   input  logic [1:0]         rsp_right_direction,
   input  logic signed [31:0] rsp_left_velocity,
   input  logic signed [31:0] rsp_right_velocity,
   input  logic [18:0]        rsp_left_angle,
   input  logic [18:0]        rsp_right_angle,
   output int                 error_count,
   output int                 drives_pending,
   output int                 drives_checked
);

   localparam longint INT32_HI = 64'sd2147483647;
   localparam longint INT32_LO = -64'sd2147483648;
   localparam longint INTEG_HI = (64'sd1 <<< 47) - 1;
   localparam longint INTEG_LO = -(64'sd1 <<< 47);
   localparam longint TURN     = 64'sd411775;

   typedef struct packed {
      logic [7:0]         left_duty;
      logic [1:0]         left_direction;
      logic [7:0]         right_duty;
      logic [1:0]         right_direction;
      logic signed [31:0] left_velocity;
      logic signed [31:0] right_velocity;
      logic [18:0]        left_angle;
      logic [18:0]        right_angle;
   } drive_type;

   drive_type expected_drives[$];

   longint     kp, ki, kd, lower;
   logic [7:0] upper;
   logic [31:0] rad_per_tick;
   logic [31:0] prev_count[2];
   longint     filt_vel[2], prev_raw[2], prev_err[2], err_sum[2], angle[2];

   function automatic longint clip32(input longint v);
      if (v > INT32_HI) return INT32_HI;
      if (v < INT32_LO) return INT32_LO;
      return v;
   endfunction

   function automatic longint gain_product(input longint a, input longint b);
      logic signed [127:0] pa, pb, p, lim;
      pa = a;
      pb = b;
      p = pa * pb;
      lim = 128'sd1 <<< 60;
      if (p > lim) p = lim;
      if (p < -lim) p = -lim;
      return longint'(p);
   endfunction

   task automatic wheel_update(input int w, input logic [31:0] cnt,
                               input logic signed [31:0] tgt, input longint dt,
                               output logic [7:0] duty, output logic [1:0] dir,
                               output logic [31:0] vel, output logic [18:0] ang);
      logic signed [31:0] delta;
      longint ticks, a, raw, err, der, sum, drive, target;
      logic [63:0] m, q;
      delta = cnt - prev_count[w];
      ticks = delta;
      target = tgt;
      m = ((ticks < 0 ? -ticks : ticks) * {32'd0, rad_per_tick}) >> 16;
      prev_count[w] = cnt;
      a = angle[w] + (ticks < 0 ? -longint'(m) : longint'(m));
      if (a > TURN) begin
         a = a % TURN;
         if (a == 0) a = TURN;
      end else if (a < 0) begin
         a = a % TURN;
         if (a != 0) a = a + TURN;
      end
      angle[w] = a;
      if (m >= (64'd1 << 37)) begin
         raw = ticks < 0 ? INT32_LO : INT32_HI;
      end else begin
         q = m * 64'd1000000 / dt;
         raw = clip32(ticks < 0 ? -longint'(q) : longint'(q));
      end
      filt_vel[w] = (23 * filt_vel[w] + raw + prev_raw[w]) / 25;
      prev_raw[w] = raw;
      err = clip32(target - filt_vel[w]);
      der = clip32((err - prev_err[w]) * 1000000 / dt);
      err_sum[w] = err_sum[w] + err * dt / 1000000;
      if (err_sum[w] > INTEG_HI) err_sum[w] = INTEG_HI;
      if (err_sum[w] < INTEG_LO) err_sum[w] = INTEG_LO;
      prev_err[w] = err;
      sum = gain_product(kp, err) + gain_product(kd, der) + gain_product(ki, err_sum[w]);
      drive = sum / 64'sd4294967296;
      if (drive > longint'(upper)) drive = upper;
      else if (drive < lower) drive = lower;
      if (target == 0 || drive == 0) begin
         duty = 8'd0;
         dir = DIR_STOP;
      end else begin
         duty = (drive > 255 || drive < -255) ? 8'd255 : 8'(drive < 0 ? -drive : drive);
         dir = drive > 0 ? DIR_FWD : DIR_REV;
      end
      vel = 32'(filt_vel[w]);
      ang = 19'(angle[w]);
   endtask

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: drive %0d field %s got %0h expected %0h",
               $time, drives_checked, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      drive_type d, e;
      if (reset) begin
         kp = KP_RESET; ki = 0; kd = 0;
         upper = UPPER_RESET; lower = LOWER_RESET; rad_per_tick = RPT_RESET;
         for (int w = 0; w < 2; w++) begin
            prev_count[w] = 0; filt_vel[w] = 0; prev_raw[w] = 0;
            prev_err[w] = 0; err_sum[w] = 0; angle[w] = 0;
         end
         expected_drives.delete();
         error_count = 0;
         drives_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KP:    kp = longint'($signed(csr_data));
               REG_KI:    ki = longint'($signed(csr_data));
               REG_KD:    kd = longint'($signed(csr_data));
               REG_UPPER: upper = csr_data[7:0];
               REG_LOWER: lower = longint'($signed(csr_data[8:0]));
               REG_RPT:   rad_per_tick = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready && req_elapsed_us >= MIN_ELAPSED) begin
            wheel_update(0, req_left_count, req_left_target, req_elapsed_us,
                         e.left_duty, e.left_direction, e.left_velocity, e.left_angle);
            wheel_update(1, req_right_count, req_right_target, req_elapsed_us,
                         e.right_duty, e.right_direction, e.right_velocity, e.right_angle);
            expected_drives.push_back(e);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               $display("%0t: drive transaction with nothing expected", $time);
               error_count++;
            end else begin
               d = expected_drives.pop_front();
               if (rsp_left_duty != d.left_duty)
                  report("left_duty", rsp_left_duty, d.left_duty);
               if (rsp_left_direction != d.left_direction)
                  report("left_direction", rsp_left_direction, d.left_direction);
               if (rsp_right_duty != d.right_duty)
                  report("right_duty", rsp_right_duty, d.right_duty);
               if (rsp_right_direction != d.right_direction)
                  report("right_direction", rsp_right_direction, d.right_direction);
               if (rsp_left_velocity != d.left_velocity)
                  report("left_velocity", rsp_left_velocity, d.left_velocity);
               if (rsp_right_velocity != d.right_velocity)
                  report("right_velocity", rsp_right_velocity, d.right_velocity);
               if (rsp_left_angle != d.left_angle)
                  report("left_angle", rsp_left_angle, d.left_angle);
               if (rsp_right_angle != d.right_angle)
                  report("right_angle", rsp_right_angle, d.right_angle);
            end
            drives_checked++;
         end
      end
      drives_pending = expected_drives.size();
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual wheel velocity PID testbench
// Drives directed and random control ticks through several gain and limit
// settings with varied handshake pressure; the checker predicts each result.
// ----------------------------------------------------------------------------
module tb_top;
   import dwvp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int ITEMS_PER_PHASE = 225;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_valid, csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;
   logic               req_valid, req_ready;
   logic signed [31:0] req_left_count, req_right_count;
   logic signed [31:0] req_left_target, req_right_target;
   logic [23:0]        req_elapsed_us;
   logic               rsp_valid, rsp_ready;
   logic [7:0]         rsp_left_duty, rsp_right_duty;
   logic [1:0]         rsp_left_direction, rsp_right_direction;
   logic signed [31:0] rsp_left_velocity, rsp_right_velocity;
   logic [18:0]        rsp_left_angle, rsp_right_angle;

   int error_count, drives_pending, drives_checked;
   int sender_idle_pct, receiver_stall_pct;
   logic hold_request;
   int hold_left, hold_seen, quiet_cycles, ticks_sent;
   logic signed [31:0] left_pos, right_pos;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dual_wheel_velocity_pid dut (.*);

   pid_tick_checker checker_inst (.*);

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_request && hold_seen == 0) begin
         hold_seen <= 1;
         hold_left <= 1500;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= receiver_stall_pct;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_tick(input logic [31:0] lc, input logic [31:0] rc,
                            input logic [31:0] lt, input logic [31:0] rt,
                            input logic [23:0] dt);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_left_count   <= lc;
      req_right_count  <= rc;
      req_left_target  <= lt;
      req_right_target <= rt;
      req_elapsed_us   <= dt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      left_pos = lc;
      right_pos = rc;
      ticks_sent++;
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_delta();
      case ($urandom_range(9))
         7:       return $urandom_range(2097152) - 1048576;
         8:       return $urandom;
         9:       return 0;
         default: return $urandom_range(4000) - 2000;
      endcase
   endfunction

   function automatic logic [31:0] random_target();
      case ($urandom_range(19))
         0, 1, 2: return 0;
         3, 4:    return $urandom;
         default: return $urandom_range(2621440) - 1310720;
      endcase
   endfunction

   function automatic logic [23:0] random_elapsed();
      case ($urandom_range(19))
         0, 1:    return $urandom_range(49999, 1);
         2:       return MIN_ELAPSED;
         3:       return $urandom_range(24'hFFFFFF, 1);
         default: return $urandom_range(150000, 50000);
      endcase
   endfunction

   task automatic set_gains(input logic [31:0] p, input logic [31:0] i,
                            input logic [31:0] d, input logic [31:0] up,
                            input logic [31:0] low, input logic [31:0] rpt);
      write_reg(REG_KP, p);
      write_reg(REG_KI, i);
      write_reg(REG_KD, d);
      write_reg(REG_UPPER, up);
      write_reg(REG_LOWER, low);
      write_reg(REG_RPT, rpt);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      csr_valid <= 1'b0; csr_index <= REG_KP; csr_data <= '0;
      req_valid <= 1'b0;
      req_left_count <= '0; req_right_count <= '0;
      req_left_target <= '0; req_right_target <= '0;
      req_elapsed_us <= '0;
      hold_request = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      ticks_sent = 0;
      left_pos = 0;
      right_pos = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: short ticks, limits of time, count wrap and extreme targets.
      send_tick(100, -100, 32'h0001_0000, 32'hFFFF_0000, 49999);
      send_tick(200, -200, 32'h0001_0000, 32'hFFFF_0000, 1);
      send_tick(100, -100, 32'h0001_0000, 32'hFFFF_0000, MIN_ELAPSED);
      send_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, MIN_ELAPSED);
      send_tick(32'h8000_0500, 32'h7FFF_F000, 0, 0, 60000);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 24'hFFFFFF);
      send_tick(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, MIN_ELAPSED);
      send_tick(1024, -1024, 32'h0005_0000, 32'hFFFB_0000, 50001);
      send_tick(1024, -1024, 32'h0005_0000, 32'hFFFB_0000, 100000);
      send_tick(2048, -2048, 0, 32'h0002_0000, 100000);
      send_tick(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 24'h555555);
      send_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 24'hAAAAAA);
      send_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000, 32'hFFFF_0000, 50000);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: set_gains(32'h0004_0000, 32'h0000_8000, 32'h0000_0100, 200, 32'hFFFF_FF6A,
                         RPT_RESET);
            2: set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF);
            3: set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 255, 32'hFFFF_FF01, 0);
            4: set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            5: set_gains($urandom_range(32'h000F_FFFF), $urandom_range(32'h0000_FFFF),
                         $urandom_range(32'h0000_FFFF), 255, 32'hFFFF_FF01, RPT_RESET);
            default: ;
         endcase
         case (phase % 4)
            1: begin sender_idle_pct = 64; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 64; end
            3: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         if (phase == 1) hold_request = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (drives_pending != 0) @(posedge clock);
            end
            send_tick(left_pos + random_delta(), right_pos + random_delta(),
                      random_target(), random_target(), random_elapsed());
         end
         drain();
      end

      $display("Sent %0d control ticks over six gain and limit settings;", ticks_sent);
      $display("%0d drive results checked under varied stalls and back-pressure.",
               drives_checked);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
